// File: hdl/acrb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the audio ring buffer.
package acrb_pkg;

   localparam int DATA_W       = 8;
   localparam int LEN_W        = 7;
   localparam int CMD_W        = 2;
   localparam int DEPTH_DEF    = 1024;
   localparam int MAX_READ_DEF = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_FRONT = 2'd1,
      CMD_BACK  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   // controller -> datapath
   typedef struct packed {
      logic push;
      logic clear;
      logic load;
      logic size;
      logic span;
      logic addr;
      logic rd;
      logic empty;
   } ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic n_zero;
      logic rd_last;
   } stat_type;

endpackage

// File: hdl/audio_capture_ring_buffer_top.sv
// Top level of the overwriting audio capture ring buffer.
//
// Input channel: an item (req_cmd, req_data_in, req_len) is taken at a rising edge with
// start high and busy low. Commands: push a byte, read front, read back, clear unread count.
// Push and clear complete in the cycle they are taken; busy stays low, so one item per
// cycle is taken for a stream of pushes.
// A read holds busy high through set-up (size, span, start address) and then a read step
// for each byte, reading the single-port byte store at one address a cycle; a read that
// returns nothing takes an empty step instead. At most MAX_READ bytes are returned.
// Result channel: each returned byte shows on the rsp_ ports for exactly one cycle with
// rsp_valid high, oldest first, rsp_last on the final byte. The first byte comes after the
// set-up states and the first store read; the last appears in the cycle busy falls. An
// empty read gives one result with rsp_no_data high. The receiver cannot hold results off.
// Reset (synchronous, active high) clears the write index, fill and unread counts and the
// sequencer; the byte store is not cleared and needs no clearing pass.
module audio_capture_ring_buffer_top #(
   parameter int DEPTH    = acrb_pkg::DEPTH_DEF,
   parameter int MAX_READ = acrb_pkg::MAX_READ_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [acrb_pkg::CMD_W-1:0]    req_cmd,
   input  logic [acrb_pkg::DATA_W-1:0]   req_data_in,
   input  logic [acrb_pkg::LEN_W-1:0]    req_len,
   output logic                          rsp_valid,
   output logic [acrb_pkg::DATA_W-1:0]   rsp_data_out,
   output logic                          rsp_last,
   output logic                          rsp_no_data,
   output logic [acrb_pkg::LEN_W-1:0]    rsp_copied_count
);
   import acrb_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   acrb_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .stat    (stat),
      .ctrl    (ctrl),
      .busy    (busy)
   );

   acrb_dp #(
      .DEPTH    (DEPTH),
      .MAX_READ (MAX_READ)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .req_cmd          (req_cmd),
      .req_data_in      (req_data_in),
      .req_len          (req_len),
      .rsp_valid        (rsp_valid),
      .rsp_data_out     (rsp_data_out),
      .rsp_last         (rsp_last),
      .rsp_no_data      (rsp_no_data),
      .rsp_copied_count (rsp_copied_count)
   );

endmodule

// File: hdl/acrb_ctrl.sv
// Sequencer for the audio ring buffer: decodes commands and steps a read through its phases.
module acrb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [acrb_pkg::CMD_W-1:0]    req_cmd,
   input  acrb_pkg::stat_type            stat,
   output acrb_pkg::ctrl_type            ctrl,
   output logic                          busy
);
   import acrb_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SIZE  = 6'b000010,
      ST_SPAN  = 6'b000100,
      ST_ADDR  = 6'b001000,
      ST_READ  = 6'b010000,
      ST_EMPTY = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (cmd_type'(req_cmd))
                  CMD_PUSH:  ctrl.push = 1'b1;
                  CMD_CLEAR: ctrl.clear = 1'b1;
                  CMD_FRONT, CMD_BACK: begin
                     ctrl.load = 1'b1;
                     state_in  = ST_SIZE;
                  end
                  default: ctrl.clear = 1'b1;
               endcase
            end
         end
         ST_SIZE: begin
            ctrl.size = 1'b1;
            state_in  = ST_SPAN;
         end
         ST_SPAN: begin
            ctrl.span = 1'b1;
            state_in  = ST_ADDR;
         end
         ST_ADDR: begin
            ctrl.addr = 1'b1;
            state_in  = stat.n_zero ? ST_EMPTY : ST_READ;
         end
         ST_READ: begin
            ctrl.rd = 1'b1;
            if (stat.rd_last) state_in = ST_IDLE;
         end
         ST_EMPTY: begin
            ctrl.empty = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: hdl/acrb_dp.sv
// Datapath of the audio ring buffer: byte store, pointers, counters and result register.
module acrb_dp #(
   parameter int DEPTH    = acrb_pkg::DEPTH_DEF,
   parameter int MAX_READ = acrb_pkg::MAX_READ_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  acrb_pkg::ctrl_type            ctrl,
   output acrb_pkg::stat_type            stat,
   input  logic [acrb_pkg::CMD_W-1:0]    req_cmd,
   input  logic [acrb_pkg::DATA_W-1:0]   req_data_in,
   input  logic [acrb_pkg::LEN_W-1:0]    req_len,
   output logic                          rsp_valid,
   output logic [acrb_pkg::DATA_W-1:0]   rsp_data_out,
   output logic                          rsp_last,
   output logic                          rsp_no_data,
   output logic [acrb_pkg::LEN_W-1:0]    rsp_copied_count
);
   import acrb_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_READ);

   logic [DATA_W-1:0] ring_mem [DEPTH];

   logic [IDX_W-1:0]  wr_idx_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  unread_ff;
   logic              is_front_ff;
   logic [LEN_W-1:0]  req_ff;
   logic [LEN_W-1:0]  n_ff;
   logic [CNT_W-1:0]  span_ff;
   logic [IDX_W-1:0]  rd_addr_ff;
   logic [LEN_W-1:0]  rem_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              out_valid_ff;
   logic              out_last_ff;
   logic              out_empty_ff;

   logic [LEN_W-1:0]  req_sat;
   logic [CMP_W-1:0]  req_ext;
   logic [CMP_W-1:0]  fill_ext;
   logic [CNT_W-1:0]  n_cnt;
   logic [CNT_W:0]    start_wrap;
   logic [IDX_W-1:0]  start_idx;

   assign req_sat  = (req_len > LEN_MAX) ? LEN_MAX : req_len;
   assign req_ext  = CMP_W'(req_ff);
   assign fill_ext = CMP_W'(fill_ff);
   assign n_cnt    = CNT_W'(n_ff);

   // start = write index minus span, modulo the depth
   assign start_wrap = (CNT_W + 1)'(wr_idx_ff) + (CNT_W + 1)'(DEPTH) - (CNT_W + 1)'(span_ff);
   assign start_idx  = (span_ff > CNT_W'(wr_idx_ff)) ? start_wrap[IDX_W-1:0]
                                                      : wr_idx_ff - span_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.push) ring_mem[wr_idx_ff] <= req_data_in;
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd) rd_data_ff <= ring_mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         fill_ff   <= '0;
         unread_ff <= '0;
      end else begin
         if (ctrl.push) begin
            wr_idx_ff <= (wr_idx_ff == IDX_LAST) ? '0 : wr_idx_ff + 1'b1;
            if (fill_ff != CNT_FULL)   fill_ff   <= fill_ff + 1'b1;
            if (unread_ff != CNT_FULL) unread_ff <= unread_ff + 1'b1;
         end
         if (ctrl.clear) unread_ff <= '0;
         if (ctrl.span) begin
            if (!is_front_ff)          unread_ff <= '0;
            else if (unread_ff < n_cnt) unread_ff <= '0;
            else                       unread_ff <= unread_ff - n_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         is_front_ff <= (cmd_type'(req_cmd) == CMD_FRONT);
         req_ff      <= req_sat;
      end
      if (ctrl.size) n_ff <= (req_ext < fill_ext) ? req_ff : fill_ff[LEN_W-1:0];
      if (ctrl.span) span_ff <= (is_front_ff && unread_ff > n_cnt) ? unread_ff : n_cnt;
      if (ctrl.addr) begin
         rd_addr_ff <= start_idx;
         rem_ff     <= n_ff;
      end else if (ctrl.rd) begin
         rd_addr_ff <= (rd_addr_ff == IDX_LAST) ? '0 : rd_addr_ff + 1'b1;
         rem_ff     <= rem_ff - 1'b1;
      end
   end

   // result register, loaded together with the store read data
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= ctrl.rd | ctrl.empty;
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd) begin
         out_last_ff  <= (rem_ff == LEN_W'(1));
         out_empty_ff <= 1'b0;
      end else if (ctrl.empty) begin
         out_last_ff  <= 1'b1;
         out_empty_ff <= 1'b1;
      end
   end

   assign stat.n_zero  = (n_ff == '0);
   assign stat.rd_last = (rem_ff == LEN_W'(1));

   assign rsp_valid        = out_valid_ff;
   assign rsp_data_out     = out_empty_ff ? '0 : rd_data_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_no_data      = out_empty_ff;
   assign rsp_copied_count = out_empty_ff ? '0 : n_ff;

endmodule
